/* rtl/ffha_pkg.sv */
package ffha_pkg;

	// arena geometry
	localparam int ARENA_BYTES    = 1048576;
	localparam int HEADER_BYTES   = 32;
	localparam int ALIGN_BYTES    = 16;
	localparam int MAX_BLOCKS_DEF = 1024;
	localparam int ALIGN_LOG      = $clog2(ALIGN_BYTES);

	// field widths
	localparam int OFF_W      = 20;
	localparam int LEN_W      = 21;
	localparam int WIDE_W     = 36;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 88;

	localparam logic [LEN_W-1:0]  CHUNK_RESET = LEN_W'(64000);
	localparam logic [WIDE_W-1:0] ARENA_W     = WIDE_W'(ARENA_BYTES);
	localparam logic [WIDE_W-1:0] HDR_W       = WIDE_W'(HEADER_BYTES);
	localparam logic [WIDE_W-1:0] SPLIT_MIN   = WIDE_W'(HEADER_BYTES + ALIGN_BYTES);

	// request kinds
	localparam logic [1:0] OP_MALLOC  = 2'd0;
	localparam logic [1:0] OP_CALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE    = 2'd2;
	localparam logic [1:0] OP_REALLOC = 2'd3;

	// result status
	localparam logic [2:0] ST_GRANTED  = 3'd0;
	localparam logic [2:0] ST_COPY     = 3'd1;
	localparam logic [2:0] ST_ZERO     = 3'd2;
	localparam logic [2:0] ST_NULL     = 3'd3;
	localparam logic [2:0] ST_OOM      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;
	localparam logic [2:0] ST_FREED    = 3'd6;
	localparam logic [2:0] ST_IGNORED  = 3'd7;

	typedef struct packed {
		logic [OFF_W-1:0] hdr;
		logic [LEN_W-1:0] len;
		logic             free;
	} entry_t;

	// round up to the alignment (power of two)
	function automatic logic [WIDE_W-1:0] align_up(input logic [WIDE_W-1:0] x);
		logic [WIDE_W-1:0] y;
		y = x + WIDE_W'(ALIGN_BYTES - 1);
		y[ALIGN_LOG-1:0] = '0;
		return y;
	endfunction

	function automatic logic [WIDE_W-1:0] data_of(input logic [OFF_W-1:0] hdr);
		return align_up(WIDE_W'(hdr) + HDR_W);
	endfunction

endpackage

/* rtl/ffha_table.sv */
module ffha_table import ffha_pkg::*; #(
	parameter int DEPTH = MAX_BLOCKS_DEF,
	parameter int AW    = $clog2(MAX_BLOCKS_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
// first-fit heap allocator: one request in, one result out per transaction
// a realloc that moves makes five passes (lookup, fit scan, tail shift, release
// lookup, coalescing)
// throughput: one request at a time, taken only while the sequencer is idle
// reset: arst_n clears the heap (no blocks, heap not started), chunk 64000
module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// chunk_bytes register
	input  logic                  cfg_we,
	input  logic [LEN_W-1:0]      cfg_wdata,
	// requests
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pointer_offset, pointer_is_null, byte_size, element_count, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// opcode
	input  logic [1:0]            s_axis_tuser,
	// results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// data_offset, block_bytes, copy_from, copy_bytes, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [2:0]            m_axis_tuser
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);

	// sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DEC   = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_ALLOC = 5'd3;
	localparam logic [4:0] S_FIT   = 5'd4;
	localparam logic [4:0] S_GROW  = 5'd5;
	localparam logic [4:0] S_SPL   = 5'd6;
	localparam logic [4:0] S_SHUP  = 5'd7;
	localparam logic [4:0] S_SPW   = 5'd8;
	localparam logic [4:0] S_SPW2  = 5'd9;
	localparam logic [4:0] S_ADONE = 5'd10;
	localparam logic [4:0] S_FIND  = 5'd11;
	localparam logic [4:0] S_NBR   = 5'd12;
	localparam logic [4:0] S_NBE   = 5'd13;
	localparam logic [4:0] S_SHDN  = 5'd14;
	localparam logic [4:0] S_MRG   = 5'd15;
	localparam logic [4:0] S_RSP   = 5'd16;

	// what follows an allocation or a pointer lookup
	localparam logic [2:0] P_GRANT   = 3'd0;
	localparam logic [2:0] P_ZERO    = 3'd1;
	localparam logic [2:0] P_MOVE    = 3'd2;
	localparam logic [2:0] P_SHRINK  = 3'd3;
	localparam logic [2:0] P_FREE    = 3'd4;
	localparam logic [2:0] P_REALLOC = 3'd5;
	localparam logic [2:0] P_MFREE   = 3'd6;

	logic [4:0]            state_q;
	logic [2:0]            post_q;
	logic [2:0]            res_st_q;

	// heap state
	logic [CW-1:0]         total_q;
	logic [LEN_W-1:0]      heap_end_q;
	logic                  started_q;
	logic [LEN_W-1:0]      chunk_q;

	// request
	logic [1:0]            op_q;
	logic [OFF_W-1:0]      ptr_q;
	logic                  null_q;
	logic [31:0]           size_q;
	logic [31:0]           cnt_q;
	logic [63:0]           prod_q;
	logic [32:0]           s_q;

	// walk state
	logic [IW-1:0]         idx_q;
	logic [CW-1:0]         k_q;
	logic [IW-1:0]         w_q;
	logic                  have_q;
	logic                  ins_q;
	entry_t                ent_q;
	entry_t                cur_q;

	// result payload
	logic [LEN_W-1:0]      old_q;
	logic [OFF_W-1:0]      od_q;
	logic [OFF_W-1:0]      gd_q;
	logic [LEN_W-1:0]      gl_q;

	// table read pipe
	logic                  rv_s1;
	logic [IW-1:0]         ra_s1;

	// output register
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [2:0]            m_tuser_q;

	// table ports
	logic                  mem_we;
	logic [IW-1:0]         mem_waddr;
	entry_t                mem_wdata;
	logic                  mem_re;
	logic [IW-1:0]         mem_raddr;
	entry_t                rd_ent;

	logic [WIDE_W-1:0]     c_eff;
	logic [WIDE_W-1:0]     s_w;
	logic [WIDE_W-1:0]     size_al;
	logic [WIDE_W-1:0]     prod_al;
	logic [WIDE_W-1:0]     rd_d;
	logic [WIDE_W-1:0]     ent_d;
	logic [WIDE_W-1:0]     spl_len;
	logic [WIDE_W-1:0]     grow_req;
	logic [WIDE_W-1:0]     grow_start;
	logic [WIDE_W-1:0]     grow_end;
	logic [WIDE_W-1:0]     nb_len;
	logic [CW-1:0]         idx_p1;
	logic                  k_lt_total;
	logic                  scan_done;
	logic                  fit_hit;
	logic                  find_hit;
	logic                  grow_ok;
	logic                  spl_ok;
	logic                  nb_ok;
	logic                  nb_split;
	logic                  mrg_join;
	logic                  res_grant;
	logic [OFF_W-1:0]      o_d;
	logic [LEN_W-1:0]      o_b;
	logic [OFF_W-1:0]      o_cf;
	logic [LEN_W-1:0]      o_cb;

	ffha_table #(
		.DEPTH (MAX_BLOCKS),
		.AW    (IW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_ent)
	);

	// arithmetic on the current table word and the latched entry
	always_comb begin
		c_eff      = (WIDE_W'(chunk_q) < SPLIT_MIN) ? SPLIT_MIN : WIDE_W'(chunk_q);
		s_w        = WIDE_W'(s_q);
		// request sizes rounded up to the alignment
		size_al    = align_up(WIDE_W'(size_q));
		prod_al    = align_up(WIDE_W'(prod_q[31:0]));
		rd_d       = data_of(rd_ent.hdr);
		ent_d      = data_of(ent_q.hdr);
		spl_len    = WIDE_W'(ent_q.len);
		idx_p1     = CW'(idx_q) + CW'(1);
		k_lt_total = k_q < total_q;
		scan_done  = !k_lt_total && !rv_s1;
		fit_hit    = rv_s1 && rd_ent.free && (WIDE_W'(rd_ent.len) >= s_w);
		find_hit   = rv_s1 && (WIDE_W'(ptr_q) >= rd_d) &&
			(WIDE_W'(ptr_q) < rd_d + WIDE_W'(rd_ent.len));
		// new region at the heap end: header plus size, at least one chunk
		grow_req   = (HDR_W + s_w > c_eff) ? HDR_W + s_w : c_eff;
		grow_start = align_up(WIDE_W'(heap_end_q));
		grow_end   = grow_start + grow_req;
		grow_ok    = (total_q < CW'(MAX_BLOCKS)) && (grow_end <= ARENA_W);
		// remainder must hold a header plus one aligned unit
		spl_ok     = (total_q < CW'(MAX_BLOCKS)) && (spl_len >= s_w) &&
			(spl_len - s_w >= SPLIT_MIN);
		// realloc grow into the following free block
		nb_len     = WIDE_W'(old_q) + HDR_W + WIDE_W'(rd_ent.len);
		nb_ok      = rd_ent.free && (nb_len >= s_w) &&
			(WIDE_W'(od_q) + WIDE_W'(old_q) == WIDE_W'(rd_ent.hdr));
		nb_split   = nb_len - s_w >= SPLIT_MIN;
		// coalescing: free, free and back to back
		mrg_join   = cur_q.free && rd_ent.free &&
			(data_of(cur_q.hdr) + WIDE_W'(cur_q.len) == WIDE_W'(rd_ent.hdr));
	end

	// table port control per state
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = k_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = ent_q;
		case (state_q)
			S_ALLOC: begin
				// first region at offset zero
				if (!started_q && c_eff <= ARENA_W) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = '{hdr: '0, len: LEN_W'(c_eff - HDR_W), free: 1'b1};
				end
			end
			S_FIT: begin
				mem_re = k_lt_total && !fit_hit;
			end
			S_GROW: begin
				if (grow_ok) begin
					mem_we    = 1'b1;
					mem_waddr = total_q[IW-1:0];
					mem_wdata = '{hdr: grow_start[OFF_W-1:0],
						len: LEN_W'(grow_req - HDR_W), free: 1'b1};
				end
			end
			S_SPL: begin
				// no split: just mark the block used
				if (!spl_ok && post_q != P_SHRINK) begin
					mem_we         = 1'b1;
					mem_wdata.free = 1'b0;
				end
			end
			S_SHUP: begin
				// move the tail up one entry, top first
				mem_re    = k_q > idx_p1;
				mem_raddr = IW'(k_q - CW'(1));
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ra_s1 + IW'(1);
					mem_wdata = rd_ent;
				end
			end
			S_SPW: begin
				mem_we    = 1'b1;
				mem_waddr = idx_p1[IW-1:0];
				mem_wdata = '{hdr: OFF_W'(ent_d + s_w),
					len: LEN_W'(spl_len - s_w - HDR_W), free: 1'b1};
			end
			S_SPW2: begin
				mem_we    = 1'b1;
				mem_wdata = '{hdr: ent_q.hdr, len: LEN_W'(s_w), free: 1'b0};
			end
			S_FIND: begin
				mem_re = k_lt_total && !find_hit;
				if (find_hit && !rd_ent.free && (post_q == P_FREE || post_q == P_MFREE)) begin
					mem_we         = 1'b1;
					mem_waddr      = ra_s1;
					mem_wdata      = rd_ent;
					mem_wdata.free = 1'b1;
				end
			end
			S_NBR: begin
				mem_re    = 1'b1;
				mem_raddr = idx_p1[IW-1:0];
			end
			S_NBE: begin
				if (nb_ok && !nb_split) begin
					mem_we    = 1'b1;
					mem_wdata = '{hdr: ent_q.hdr, len: LEN_W'(nb_len), free: 1'b0};
				end
			end
			S_SHDN: begin
				// close the gap left by the absorbed neighbor
				mem_re = k_lt_total;
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ra_s1 - IW'(1);
					mem_wdata = rd_ent;
				end
			end
			S_MRG: begin
				// compacting pass: write index trails read index
				mem_re = k_lt_total;
				if ((rv_s1 && have_q && !mrg_join) || (scan_done && have_q)) begin
					mem_we    = 1'b1;
					mem_waddr = w_q;
					mem_wdata = cur_q;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields by status
	always_comb begin
		res_grant = (res_st_q == ST_GRANTED) || (res_st_q == ST_COPY) ||
			(res_st_q == ST_ZERO);
		o_d  = res_grant ? gd_q : '0;
		o_b  = res_grant ? gl_q : '0;
		o_cf = (res_st_q == ST_COPY) ? od_q : '0;
		o_cb = (res_st_q == ST_COPY) ? old_q :
			(res_st_q == ST_ZERO) ? prod_q[LEN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			post_q     <= P_GRANT;
			res_st_q   <= ST_NULL;
			total_q    <= '0;
			heap_end_q <= '0;
			started_q  <= 1'b0;
			chunk_q    <= CHUNK_RESET;
			rv_s1      <= 1'b0;
			ra_s1      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			op_q       <= '0;
			ptr_q      <= '0;
			null_q     <= 1'b0;
			size_q     <= '0;
			cnt_q      <= '0;
			prod_q     <= '0;
			s_q        <= '0;
			idx_q      <= '0;
			k_q        <= '0;
			w_q        <= '0;
			have_q     <= 1'b0;
			ins_q      <= 1'b0;
			ent_q      <= '0;
			cur_q      <= '0;
			old_q      <= '0;
			od_q       <= '0;
			gd_q       <= '0;
			gl_q       <= '0;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			rv_s1 <= mem_re;
			ra_s1 <= mem_raddr;
			if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tuser;
						ptr_q   <= s_axis_tdata[19:0];
						null_q  <= s_axis_tdata[20];
						size_q  <= s_axis_tdata[52:21];
						cnt_q   <= s_axis_tdata[84:53];
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					s_q    <= size_al[32:0];
					prod_q <= size_q * cnt_q;
					k_q    <= '0;
					case (op_q)
						OP_MALLOC: begin
							post_q <= P_GRANT;
							if (size_q == '0) begin
								res_st_q <= ST_NULL;
								state_q  <= S_RSP;
							end else begin
								state_q <= S_ALLOC;
							end
						end
						OP_CALLOC: begin
							if (size_q == '0 || cnt_q == '0) begin
								res_st_q <= ST_NULL;
								state_q  <= S_RSP;
							end else begin
								state_q <= S_CHK;
							end
						end
						OP_FREE: begin
							post_q <= P_FREE;
							if (null_q) begin
								res_st_q <= ST_IGNORED;
								state_q  <= S_RSP;
							end else begin
								state_q <= S_FIND;
							end
						end
						OP_REALLOC: begin
							if (null_q) begin
								post_q <= P_GRANT;
								if (size_q == '0) begin
									res_st_q <= ST_NULL;
									state_q  <= S_RSP;
								end else begin
									state_q <= S_ALLOC;
								end
							end else begin
								post_q  <= (size_q == '0) ? P_FREE : P_REALLOC;
								state_q <= S_FIND;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CHK: begin
					if (prod_q[63:32] != '0) begin
						res_st_q <= ST_OVERFLOW;
						state_q  <= S_RSP;
					end else begin
						s_q     <= prod_al[32:0];
						post_q  <= P_ZERO;
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					k_q <= '0;
					if (!started_q) begin
						if (c_eff > ARENA_W) begin
							res_st_q <= ST_OOM;
							state_q  <= S_RSP;
						end else begin
							total_q    <= CW'(1);
							heap_end_q <= LEN_W'(c_eff);
							started_q  <= 1'b1;
						end
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (mem_re) begin
						k_q <= k_q + CW'(1);
					end
					if (fit_hit) begin
						idx_q   <= ra_s1;
						ent_q   <= rd_ent;
						state_q <= S_SPL;
					end else if (scan_done) begin
						state_q <= S_GROW;
					end
				end
				S_GROW: begin
					if (grow_ok) begin
						idx_q      <= total_q[IW-1:0];
						ent_q      <= '{hdr: grow_start[OFF_W-1:0],
							len: LEN_W'(grow_req - HDR_W), free: 1'b1};
						total_q    <= total_q + CW'(1);
						heap_end_q <= LEN_W'(grow_end);
						state_q    <= S_SPL;
					end else begin
						res_st_q <= ST_OOM;
						state_q  <= S_RSP;
					end
				end
				S_SPL: begin
					gd_q <= OFF_W'(ent_d);
					gl_q <= spl_ok ? LEN_W'(s_w) : ent_q.len;
					if (spl_ok) begin
						k_q     <= total_q;
						ins_q   <= 1'b1;
						state_q <= S_SHUP;
					end else begin
						state_q <= S_ADONE;
					end
				end
				S_SHUP: begin
					if (mem_re) begin
						k_q <= k_q - CW'(1);
					end
					if (k_q == idx_p1 && !rv_s1) begin
						state_q <= S_SPW;
					end
				end
				S_SPW: begin
					state_q <= S_SPW2;
				end
				S_SPW2: begin
					if (ins_q) begin
						total_q <= total_q + CW'(1);
					end
					state_q <= S_ADONE;
				end
				S_ADONE: begin
					k_q    <= '0;
					w_q    <= '0;
					have_q <= 1'b0;
					case (post_q)
						P_ZERO: begin
							res_st_q <= ST_ZERO;
							state_q  <= S_RSP;
						end
						P_MOVE: begin
							// new block granted, now release the old one
							ptr_q   <= od_q;
							post_q  <= P_MFREE;
							state_q <= S_FIND;
						end
						P_SHRINK: begin
							res_st_q <= ST_GRANTED;
							state_q  <= S_MRG;
						end
						default: begin
							res_st_q <= ST_GRANTED;
							state_q  <= S_RSP;
						end
					endcase
				end
				S_FIND: begin
					if (mem_re) begin
						k_q <= k_q + CW'(1);
					end
					if (find_hit && !rd_ent.free) begin
						idx_q <= ra_s1;
						ent_q <= rd_ent;
						if (post_q == P_REALLOC) begin
							old_q <= rd_ent.len;
							od_q  <= OFF_W'(rd_d);
							if (s_w <= WIDE_W'(rd_ent.len)) begin
								post_q  <= P_SHRINK;
								state_q <= S_SPL;
							end else if (CW'(ra_s1) + CW'(1) < total_q) begin
								state_q <= S_NBR;
							end else begin
								post_q  <= P_MOVE;
								state_q <= S_ALLOC;
							end
						end else begin
							res_st_q <= (post_q == P_MFREE) ? ST_COPY : ST_FREED;
							k_q      <= '0;
							w_q      <= '0;
							have_q   <= 1'b0;
							state_q  <= S_MRG;
						end
					end else if (find_hit || scan_done) begin
						// pointer inside no used block
						res_st_q <= (post_q == P_MFREE) ? ST_COPY : ST_IGNORED;
						state_q  <= S_RSP;
					end
				end
				S_NBR: begin
					state_q <= S_NBE;
				end
				S_NBE: begin
					if (nb_ok) begin
						gd_q <= od_q;
						if (nb_split) begin
							ent_q.len <= LEN_W'(nb_len);
							ins_q     <= 1'b0;
							gl_q      <= LEN_W'(s_w);
							state_q   <= S_SPW;
						end else begin
							gl_q    <= LEN_W'(nb_len);
							k_q     <= idx_p1 + CW'(1);
							state_q <= S_SHDN;
						end
					end else begin
						post_q  <= P_MOVE;
						state_q <= S_ALLOC;
					end
				end
				S_SHDN: begin
					if (mem_re) begin
						k_q <= k_q + CW'(1);
					end
					if (scan_done) begin
						total_q  <= total_q - CW'(1);
						res_st_q <= ST_GRANTED;
						state_q  <= S_RSP;
					end
				end
				S_MRG: begin
					if (mem_re) begin
						k_q <= k_q + CW'(1);
					end
					if (rv_s1) begin
						if (!have_q) begin
							cur_q  <= rd_ent;
							have_q <= 1'b1;
						end else if (mrg_join) begin
							cur_q.len <= LEN_W'(WIDE_W'(cur_q.len) + HDR_W +
								WIDE_W'(rd_ent.len));
						end else begin
							w_q   <= w_q + IW'(1);
							cur_q <= rd_ent;
						end
					end else if (scan_done && have_q) begin
						total_q <= CW'(w_q) + CW'(1);
						state_q <= S_RSP;
					end
				end
				S_RSP: begin
					// result register free or being drained this cycle
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_st_q;
						m_tdata_q  <= {6'd0, o_cb, o_cf, o_b, o_d};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a new request is taken while an earlier result still waits
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

/* rtl/ffha_check.sv */
module ffha_check import ffha_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]            m_axis_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// one request in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// no payload without a grant
	a_nopay: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_NULL || m_axis_tuser == ST_OOM ||
		m_axis_tuser == ST_OVERFLOW || m_axis_tuser == ST_FREED ||
		m_axis_tuser == ST_IGNORED) |-> m_axis_tdata == '0)
		else $error("payload on non-grant");

	// granted block is aligned and not empty
	a_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_GRANTED || m_axis_tuser == ST_COPY ||
		m_axis_tuser == ST_ZERO) |->
		m_axis_tdata[ALIGN_LOG-1:0] == '0 && m_axis_tdata[40:20] != '0)
		else $error("bad grant");

endmodule

bind first_fit_heap_allocator_top ffha_check u_check (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import ffha_pkg::*;

	typedef struct {
		logic [2:0]  st;
		logic [19:0] d;
		logic [20:0] b;
		logic [19:0] cf;
		logic [20:0] cb;
	} heap_result_t;

	// pointer source for a directed row
	localparam int PTR_LIT  = 0;
	localparam int PTR_LAST = 1;
	localparam int PTR_PREV = 2;

	typedef struct {
		logic [1:0]   op;
		int           psel;
		logic [19:0]  ptr;
		bit           isnull;
		logic [31:0]  size;
		logic [31:0]  cnt;
		bit           fixed;
		heap_result_t r;
	} req_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	first_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	// shadow block table
	localparam int TAB = 1024;
	bit [19:0] shadow_hdr[TAB];
	bit [20:0] shadow_len[TAB];
	bit        shadow_free[TAB];
	int        shadow_total = 0;
	longint unsigned shadow_end = 0;
	bit        shadow_started = 0;
	bit [20:0] shadow_chunk = 21'd64000;

	heap_result_t grant_q[$];
	logic [19:0] live_ptrs[$];
	logic [19:0] last_grant = '0, prev_grant = '0;
	int errors = 0;
	bit idle_on = 0;
	bit stall_req = 0, stall_done = 0;
	int hold_cnt = 0;

	function automatic longint unsigned rnd_align(longint unsigned x);
		return (x + 15) & ~64'd15;
	endfunction

	function automatic longint unsigned data_at(int i);
		return rnd_align(longint'(shadow_hdr[i]) + HEADER_BYTES);
	endfunction

	function automatic longint unsigned chunk_used();
		return (shadow_chunk < 48) ? 48 : longint'(shadow_chunk);
	endfunction

	function automatic void drop_entry(int i);
		for (int j = i; j < shadow_total - 1; j++) begin
			shadow_hdr[j] = shadow_hdr[j+1];
			shadow_len[j] = shadow_len[j+1];
			shadow_free[j] = shadow_free[j+1];
		end
		shadow_total--;
	endfunction

	function automatic void carve(int i, longint unsigned s);
		longint unsigned len;
		len = shadow_len[i];
		if (shadow_total >= TAB || len < s || len - s < 48)
			return;
		for (int j = shadow_total - 1; j > i; j--) begin
			shadow_hdr[j+1] = shadow_hdr[j];
			shadow_len[j+1] = shadow_len[j];
			shadow_free[j+1] = shadow_free[j];
		end
		shadow_hdr[i+1] = 20'(data_at(i) + s);
		shadow_len[i+1] = 21'(len - s - HEADER_BYTES);
		shadow_free[i+1] = 1;
		shadow_len[i] = 21'(s);
		shadow_total++;
	endfunction

	function automatic void coalesce();
		int i;
		i = 0;
		while (i + 1 < shadow_total) begin
			if (shadow_free[i] && shadow_free[i+1] &&
			    data_at(i) + shadow_len[i] == longint'(shadow_hdr[i+1])) begin
				shadow_len[i] = 21'(longint'(shadow_len[i]) + HEADER_BYTES + shadow_len[i+1]);
				drop_entry(i + 1);
			end else begin
				i++;
			end
		end
	endfunction

	function automatic bit open_heap();
		longint unsigned c;
		if (shadow_started)
			return 1;
		c = chunk_used();
		if (c > ARENA_BYTES)
			return 0;
		shadow_hdr[0] = 0;
		shadow_len[0] = 21'(c - HEADER_BYTES);
		shadow_free[0] = 1;
		shadow_total = 1;
		shadow_end = c;
		shadow_started = 1;
		return 1;
	endfunction

	function automatic int extend(longint unsigned s);
		longint unsigned need, req, start, stop;
		need = HEADER_BYTES + s;
		req = need > chunk_used() ? need : chunk_used();
		start = rnd_align(shadow_end);
		stop = rnd_align(start + HEADER_BYTES) + req - HEADER_BYTES;
		if (shadow_total >= TAB || stop > ARENA_BYTES)
			return -1;
		shadow_hdr[shadow_total] = 20'(start);
		shadow_len[shadow_total] = 21'(req - HEADER_BYTES);
		shadow_free[shadow_total] = 1;
		shadow_total++;
		shadow_end = stop;
		return shadow_total - 1;
	endfunction

	function automatic logic [2:0] place(longint unsigned size, output int idx);
		longint unsigned s;
		int i, g;
		idx = 0;
		if (size == 0)
			return ST_NULL;
		if (!open_heap())
			return ST_OOM;
		s = rnd_align(size);
		for (i = 0; i < shadow_total; i++)
			if (shadow_free[i] && shadow_len[i] >= s)
				break;
		if (i == shadow_total) begin
			g = extend(s);
			if (g < 0)
				return ST_OOM;
			i = g;
		end
		carve(i, s);
		shadow_free[i] = 0;
		idx = i;
		return ST_GRANTED;
	endfunction

	function automatic int owner_of(longint unsigned p);
		longint unsigned d;
		for (int i = 0; i < shadow_total; i++) begin
			d = data_at(i);
			if (p >= d && p < d + shadow_len[i])
				return shadow_free[i] ? -1 : i;
		end
		return -1;
	endfunction

	function automatic logic [2:0] release_at(longint unsigned p);
		int f;
		f = owner_of(p);
		if (f < 0)
			return ST_IGNORED;
		shadow_free[f] = 1;
		coalesce();
		return ST_FREED;
	endfunction

	function automatic heap_result_t mk(logic [2:0] st, longint unsigned d, longint unsigned b,
			longint unsigned cf, longint unsigned cb);
		heap_result_t r;
		r.st = st; r.d = 20'(d); r.b = 21'(b); r.cf = 20'(cf); r.cb = 21'(cb);
		return r;
	endfunction

	// next allocator state and the result of one request
	function automatic heap_result_t heap_predict(logic [1:0] op, logic [19:0] ptr, bit isnull,
			logic [31:0] size, logic [31:0] cnt);
		logic [2:0] st;
		int i, f, ni;
		longint unsigned total, s, old, od, len, nd, nl;
		case (op)
			OP_MALLOC: begin
				st = place(size, i);
				return st == ST_GRANTED ? mk(st, data_at(i), shadow_len[i], 0, 0)
				                        : mk(st, 0, 0, 0, 0);
			end
			OP_CALLOC: begin
				if (cnt == 0 || size == 0)
					return mk(ST_NULL, 0, 0, 0, 0);
				total = longint'(cnt) * longint'(size);
				if (total > 64'hFFFF_FFFF)
					return mk(ST_OVERFLOW, 0, 0, 0, 0);
				st = place(total, i);
				return st == ST_GRANTED ? mk(ST_ZERO, data_at(i), shadow_len[i], 0, total)
				                        : mk(st, 0, 0, 0, 0);
			end
			OP_FREE: begin
				if (isnull)
					return mk(ST_IGNORED, 0, 0, 0, 0);
				return mk(release_at(ptr), 0, 0, 0, 0);
			end
			default: begin
				if (isnull) begin
					st = place(size, i);
					return st == ST_GRANTED ? mk(st, data_at(i), shadow_len[i], 0, 0)
					                        : mk(st, 0, 0, 0, 0);
				end
				if (size == 0)
					return mk(release_at(ptr), 0, 0, 0, 0);
				f = owner_of(ptr);
				if (f < 0)
					return mk(ST_IGNORED, 0, 0, 0, 0);
				old = shadow_len[f];
				od = data_at(f);
				s = rnd_align(size);
				if (s <= old) begin
					carve(f, s);
					len = shadow_len[f];
					coalesce();
					return mk(ST_GRANTED, od, len, 0, 0);
				end
				if (f + 1 < shadow_total && shadow_free[f+1] &&
				    od + old == longint'(shadow_hdr[f+1]) &&
				    old + HEADER_BYTES + shadow_len[f+1] >= s) begin
					shadow_len[f] = 21'(old + HEADER_BYTES + shadow_len[f+1]);
					drop_entry(f + 1);
					carve(f, s);
					return mk(ST_GRANTED, data_at(f), shadow_len[f], 0, 0);
				end
				st = place(s, ni);
				if (st != ST_GRANTED)
					return mk(st, 0, 0, 0, 0);
				nd = data_at(ni);
				nl = shadow_len[ni];
				void'(release_at(od));
				return mk(ST_COPY, nd, nl, od, old);
			end
		endcase
	endfunction

	// one request transaction, prediction taken at acceptance
	task automatic send_req(logic [1:0] op, logic [19:0] ptr, bit isnull, logic [31:0] size,
			logic [31:0] cnt, bit fixed, heap_result_t typed);
		heap_result_t r;
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= {3'b0, cnt, size, isnull, ptr};
		do @(posedge clk); while (!s_axis_tready);
		r = heap_predict(op, ptr, isnull, size, cnt);
		grant_q.push_back(fixed ? typed : r);
		if (r.st == ST_GRANTED || r.st == ST_COPY || r.st == ST_ZERO) begin
			prev_grant = last_grant;
			last_grant = r.d;
			live_ptrs.push_back(r.d);
			if (live_ptrs.size() > 40)
				void'(live_ptrs.pop_front());
		end
		while (idle_on && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (grant_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_chunk(logic [20:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		shadow_chunk = v;
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		logic [1:0] op;
		logic [19:0] ptr;
		logic [31:0] size, cnt;
		bit isnull;
		for (int k = 0; k < n; k++) begin
			op = 2'($urandom_range(3));
			isnull = ($urandom_range(99) < 8);
			if (live_ptrs.size() != 0 && $urandom_range(99) < 75)
				ptr = live_ptrs[$urandom_range(live_ptrs.size() - 1)];
			else
				ptr = 20'($urandom);
			// sizes mostly small, a few full width
			if ($urandom_range(99) < 10)
				size = $urandom;
			else if ($urandom_range(99) < 5)
				size = 0;
			else
				size = $urandom_range(1, 3000);
			if ($urandom_range(99) < 10)
				cnt = $urandom;
			else
				cnt = $urandom_range(0, 8);
			send_req(op, ptr, isnull, size, cnt, 0, mk(0, 0, 0, 0, 0));
		end
	endtask

	// result checker and receiver backpressure
	always @(posedge clk) begin
		heap_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result st=%0d tdata=%h", $time, m_axis_tuser,
				         m_axis_tdata);
				errors++;
			end else begin
				e = grant_q.pop_front();
				if (m_axis_tuser !== e.st || m_axis_tdata[19:0] !== e.d ||
				    m_axis_tdata[40:20] !== e.b || m_axis_tdata[60:41] !== e.cf ||
				    m_axis_tdata[81:61] !== e.cb) begin
					$display("%0t: mismatch expected st=%0d d=%h b=%h cf=%h cb=%h", $time,
					         e.st, e.d, e.b, e.cf, e.cb);
					$display("%0t:          actual   st=%0d d=%h b=%h cf=%h cb=%h", $time,
					         m_axis_tuser, m_axis_tdata[19:0], m_axis_tdata[40:20],
					         m_axis_tdata[60:41], m_axis_tdata[81:61]);
					errors++;
				end
			end
		end
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 0;
		end else if (stall_req && !stall_done) begin
			stall_done <= 1;
			hold_cnt <= 3000;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= !(idle_on && $urandom_range(99) < 28) && arst_n;
		end
	end

	initial begin
		#200000000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		req_row_t rows[$];
		req_row_t row;
		logic [19:0] p;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: special cases first, then a grow / shrink / move sequence
		row = '{op: OP_FREE, psel: PTR_LIT, ptr: 0, isnull: 1, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_IGNORED, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_NULL, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_CALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 5, cnt: 0, fixed: 1,
		        r: mk(ST_NULL, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_CALLOC, psel: PTR_LIT, ptr: '1, isnull: 0, size: '1, cnt: '1, fixed: 1,
		        r: mk(ST_OVERFLOW, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LIT, ptr: 0, isnull: 1, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_NULL, 0, 0, 0, 0)};
		rows.push_back(row);
		// heap start, first block at data offset 32
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 1, cnt: 0, fixed: 1,
		        r: mk(ST_GRANTED, 32, 16, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: '1, cnt: 0, fixed: 1,
		        r: mk(ST_OOM, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 1048576, cnt: 0,
		        fixed: 1, r: mk(ST_OOM, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_CALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 5, cnt: 3, fixed: 0,
		        r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		// offset 0 lies in a header, not in data
		row = '{op: OP_FREE, psel: PTR_LIT, ptr: 0, isnull: 0, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_IGNORED, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_FREE, psel: PTR_LIT, ptr: 32, isnull: 0, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_FREED, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_FREE, psel: PTR_LIT, ptr: 32, isnull: 0, size: 0, cnt: 0, fixed: 1,
		        r: mk(ST_IGNORED, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LIT, ptr: 0, isnull: 1, size: 100, cnt: '1,
		        fixed: 0, r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		// grow into free successor, then shrink in place
		row = '{op: OP_REALLOC, psel: PTR_LAST, ptr: 0, isnull: 0, size: 400, cnt: 0,
		        fixed: 0, r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LAST, ptr: 0, isnull: 0, size: 16, cnt: 0,
		        fixed: 0, r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		// a used neighbor forces a move
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 64, cnt: 0, fixed: 0,
		        r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_MALLOC, psel: PTR_LIT, ptr: 0, isnull: 0, size: 64, cnt: 0, fixed: 0,
		        r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_PREV, ptr: 0, isnull: 0, size: 5000, cnt: 0,
		        fixed: 0, r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		// realloc too large for the arena keeps the block
		row = '{op: OP_REALLOC, psel: PTR_LAST, ptr: 0, isnull: 0, size: '1, cnt: 0, fixed: 0,
		        r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LAST, ptr: 0, isnull: 0, size: 0, cnt: 0, fixed: 0,
		        r: mk(0, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LIT, ptr: '1, isnull: 0, size: 5, cnt: 0, fixed: 1,
		        r: mk(ST_IGNORED, 0, 0, 0, 0)};
		rows.push_back(row);
		row = '{op: OP_REALLOC, psel: PTR_LIT, ptr: 20'h12345, isnull: 0, size: 0, cnt: 0,
		        fixed: 1, r: mk(ST_IGNORED, 0, 0, 0, 0)};
		rows.push_back(row);

		foreach (rows[k]) begin
			p = rows[k].psel == PTR_LAST ? last_grant :
			    rows[k].psel == PTR_PREV ? prev_grant : rows[k].ptr;
			send_req(rows[k].op, p, rows[k].isnull, rows[k].size, rows[k].cnt,
			         rows[k].fixed, rows[k].r);
		end
		drain();

		// smallest chunk, idling on, long receiver hold-off in the middle
		write_chunk(21'd64);
		idle_on = 1;
		random_phase(50);
		stall_req = 1;
		random_phase(50);
		// sender pause until every result is back
		drain();

		// largest chunk, no idling at all
		write_chunk(21'd1048576);
		idle_on = 0;
		random_phase(70);
		drain();

		write_chunk(21'd4096);
		idle_on = 1;
		random_phase(100);
		drain();

		repeat (3200) @(posedge clk);
		if (errors == 0 && grant_q.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
